// ----- rtl/core/jmsp_pkg.sv -----
// Package for the JPEG marker segment parser: payload types, phase codes, helpers.
package jmsp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_item_t;

    typedef struct packed {
        logic        valid_jpeg;
        logic        progressive;
        logic [15:0] height;
        logic [15:0] width;
        logic [7:0]  components;
        logic [2:0]  subsampling;
        logic [15:0] scans;
        logic [15:0] dqt_tables;
        logic        jfif_seen;
        logic        exif_seen;
        logic        icc_seen;
        logic        adobe_seen;
    } out_item_t;

    // Step budget; the counter is one bit wider so it can hold the limit itself.
    localparam logic [16:0] MAX_STEPS = 17'd65536;

    // Parser phases
    localparam logic [3:0] PH_SOI_FF  = 4'd0;
    localparam logic [3:0] PH_SOI_D8  = 4'd1;
    localparam logic [3:0] PH_IDLE    = 4'd2;
    localparam logic [3:0] PH_SAW_FF  = 4'd3;
    localparam logic [3:0] PH_LEN_HI  = 4'd4;
    localparam logic [3:0] PH_LEN_LO  = 4'd5;
    localparam logic [3:0] PH_PAYLOAD = 4'd6;
    localparam logic [3:0] PH_SCAN    = 4'd7;
    localparam logic [3:0] PH_SCAN_FF = 4'd8;
    localparam logic [3:0] PH_DONE    = 4'd9;

    // Marker codes
    localparam logic [7:0] M_FF   = 8'hFF;
    localparam logic [7:0] M_SOI  = 8'hD8;
    localparam logic [7:0] M_EOI  = 8'hD9;
    localparam logic [7:0] M_SOS  = 8'hDA;
    localparam logic [7:0] M_DQT  = 8'hDB;
    localparam logic [7:0] M_TEM  = 8'h01;
    localparam logic [7:0] M_APP0 = 8'hE0;
    localparam logic [7:0] M_APP1 = 8'hE1;
    localparam logic [7:0] M_APP2 = 8'hE2;
    localparam logic [7:0] M_APPE = 8'hEE;

    // Subsampling codes
    localparam logic [2:0] SS_UNKNOWN = 3'd0;
    localparam logic [2:0] SS_GRAY    = 3'd1;
    localparam logic [2:0] SS_444     = 3'd2;
    localparam logic [2:0] SS_422     = 3'd3;
    localparam logic [2:0] SS_420     = 3'd4;
    localparam logic [2:0] SS_440     = 3'd5;
    localparam logic [2:0] SS_411     = 3'd6;

    function automatic logic is_frame_marker(input logic [7:0] m);
        return (m[7:4] == 4'hC) && (m != 8'hC4) && (m != 8'hC8) && (m != 8'hCC);
    endfunction

    function automatic logic is_rst(input logic [7:0] b);
        return b[7:3] == 5'b11010;
    endfunction

    // Expected tag character for an APP segment at a payload position.
    function automatic logic [7:0] tag_char(input logic [7:0] m, input logic [3:0] pos);
        logic [7:0] c;
        c = 8'h00;
        case (m)
            M_APP0: begin
                case (pos)
                    4'd0: c = "J"; 4'd1: c = "F"; 4'd2: c = "I"; 4'd3: c = "F";
                    default: c = 8'h00;
                endcase
            end
            M_APP1: begin
                case (pos)
                    4'd0: c = "E"; 4'd1: c = "x"; 4'd2: c = "i"; 4'd3: c = "f";
                    default: c = 8'h00;
                endcase
            end
            M_APPE: begin
                case (pos)
                    4'd0: c = "A"; 4'd1: c = "d"; 4'd2: c = "o"; 4'd3: c = "b";
                    default: c = 8'h00;
                endcase
            end
            M_APP2: begin
                case (pos)
                    4'd0: c = "I"; 4'd1: c = "C"; 4'd2: c = "C"; 4'd3: c = "_";
                    4'd4: c = "P"; 4'd5: c = "R"; 4'd6: c = "O"; 4'd7: c = "F";
                    4'd8: c = "I"; 4'd9: c = "L"; 4'd10: c = "E";
                    default: c = 8'h00;
                endcase
            end
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [3:0] fix_factor(input logic [3:0] f);
        return (f == 4'd0) ? 4'd1 : f;
    endfunction

    function automatic logic [2:0] subsampling_code(input logic [15:0] sf,
                                                    input logic [7:0] comps);
        logic [5:0] h0, v0, h1, v1;
        logic [2:0] r;
        h0 = {2'b00, fix_factor(sf[15:12])};
        v0 = {2'b00, fix_factor(sf[11:8])};
        h1 = {2'b00, fix_factor(sf[7:4])};
        v1 = {2'b00, fix_factor(sf[3:0])};
        if (comps == 8'd1) r = SS_GRAY;
        else if (h0 == h1 && v0 == v1) r = SS_444;
        else if (h0 == (h1 << 1) && v0 == v1) r = SS_422;
        else if (h0 == (h1 << 1) && v0 == (v1 << 1)) r = SS_420;
        else if (h0 == h1 && v0 == (v1 << 1)) r = SS_440;
        else if (h0 == (h1 << 2) && v0 == v1) r = SS_411;
        else r = SS_UNKNOWN;
        return r;
    endfunction

    function automatic logic [15:0] sat_add(input logic [15:0] v, input logic [2:0] a);
        logic [16:0] s;
        s = {1'b0, v} + {14'd0, a};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

// ----- rtl/core/jmsp_parse_core.sv -----
// Per-byte parser datapath: next-state logic for the marker segment walker.
module jmsp_parse_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  jmsp_pkg::in_item_t item,
    output jmsp_pkg::out_item_t info_next
);

    logic [3:0]  phase_reg, phase_next;
    logic [7:0]  marker_reg, marker_next;
    logic [15:0] seglen_reg, seglen_next;
    logic [15:0] pos_reg, pos_next;
    logic [16:0] steps_reg, steps_next;
    logic [2:0]  dqt_idx_reg, dqt_idx_next;
    logic [7:0]  dqt_pos_reg, dqt_pos_next;
    logic [2:0]  dqt_cnt_reg, dqt_cnt_next;
    logic [39:0] sof_reg, sof_next;
    logic [15:0] sf_reg, sf_next;
    logic        tag_ok_reg, tag_ok_next;
    jmsp_pkg::out_item_t info_reg, info_upd;

    logic [7:0]  b;
    logic [15:0] plen, pos_inc;
    logic        step_ok, commit;
    logic [7:0]  comps;

    assign b       = item.data_byte;
    assign plen    = seglen_reg - 16'd2;
    assign pos_inc = pos_reg + 16'd1;
    assign step_ok = steps_reg < jmsp_pkg::MAX_STEPS;
    assign comps   = sof_reg[39:32];

    // Phase walk and pending segment state
    always_comb begin
        phase_next   = phase_reg;
        marker_next  = marker_reg;
        seglen_next  = seglen_reg;
        pos_next     = pos_reg;
        steps_next   = steps_reg;
        dqt_idx_next = dqt_idx_reg;
        dqt_pos_next = dqt_pos_reg;
        dqt_cnt_next = dqt_cnt_reg;
        sof_next     = sof_reg;
        sf_next      = sf_reg;
        tag_ok_next  = tag_ok_reg;
        commit       = 1'b0;

        // Marker handling after an FF, shared by idle and scan paths
        unique case (phase_reg) inside
            jmsp_pkg::PH_SOI_FF: begin
                phase_next = (b == jmsp_pkg::M_FF) ? jmsp_pkg::PH_SOI_D8 : jmsp_pkg::PH_DONE;
            end
            jmsp_pkg::PH_SOI_D8: begin
                phase_next = (b == jmsp_pkg::M_SOI) ? jmsp_pkg::PH_IDLE : jmsp_pkg::PH_DONE;
            end
            jmsp_pkg::PH_IDLE: begin
                if (!step_ok) begin
                    phase_next = jmsp_pkg::PH_DONE;
                end else begin
                    steps_next = steps_reg + 17'd1;
                    if (b == jmsp_pkg::M_FF) phase_next = jmsp_pkg::PH_SAW_FF;
                end
            end
            jmsp_pkg::PH_SAW_FF, jmsp_pkg::PH_SCAN_FF: begin
                if (phase_reg == jmsp_pkg::PH_SCAN_FF &&
                    (b == 8'h00 || jmsp_pkg::is_rst(b))) begin
                    phase_next = jmsp_pkg::PH_SCAN;
                end else if (phase_reg == jmsp_pkg::PH_SCAN_FF && !step_ok) begin
                    phase_next = jmsp_pkg::PH_DONE;
                end else begin
                    // scan exit already used one step; fill FF uses another
                    if (phase_reg == jmsp_pkg::PH_SCAN_FF) steps_next = steps_reg + 17'd1;
                    if (b == jmsp_pkg::M_FF) begin
                        if (steps_next >= jmsp_pkg::MAX_STEPS) begin
                            phase_next = jmsp_pkg::PH_DONE;
                        end else begin
                            steps_next = steps_next + 17'd1;
                            phase_next = jmsp_pkg::PH_SAW_FF;
                        end
                    end else if (b == jmsp_pkg::M_SOI || b == jmsp_pkg::M_TEM ||
                                 jmsp_pkg::is_rst(b)) begin
                        phase_next = jmsp_pkg::PH_IDLE;
                    end else if (b == jmsp_pkg::M_EOI) begin
                        phase_next = jmsp_pkg::PH_DONE;
                    end else begin
                        marker_next = b;
                        phase_next  = jmsp_pkg::PH_LEN_HI;
                    end
                end
            end
            jmsp_pkg::PH_LEN_HI: begin
                seglen_next = {b, 8'h00};
                phase_next  = jmsp_pkg::PH_LEN_LO;
            end
            jmsp_pkg::PH_LEN_LO: begin
                seglen_next = {seglen_reg[15:8], b};
                if (seglen_next < 16'd2) begin
                    phase_next = jmsp_pkg::PH_DONE;
                end else begin
                    pos_next     = 16'd0;
                    dqt_idx_next = 3'd0;
                    dqt_pos_next = 8'd0;
                    dqt_cnt_next = 3'd0;
                    sof_next     = 40'd0;
                    sf_next      = 16'h1111;
                    tag_ok_next  = 1'b1;
                    if (seglen_next == 16'd2) commit = 1'b1;
                    else phase_next = jmsp_pkg::PH_PAYLOAD;
                end
            end
            jmsp_pkg::PH_PAYLOAD: begin
                if (marker_reg == jmsp_pkg::M_DQT) begin
                    if (dqt_idx_reg < 3'd4) begin
                        if (dqt_pos_reg == 8'd0) begin
                            if (b[3:0] >= 4'd4) begin
                                dqt_idx_next = 3'd4;
                            end else begin
                                dqt_pos_next = (b[7:4] != 4'd0) ? 8'd128 : 8'd64;
                                dqt_idx_next = dqt_idx_reg + 3'd1;
                            end
                        end else begin
                            dqt_pos_next = dqt_pos_reg - 8'd1;
                            if (dqt_pos_next == 8'd0) dqt_cnt_next = dqt_cnt_reg + 3'd1;
                        end
                    end
                end else if (jmsp_pkg::is_frame_marker(marker_reg)) begin
                    if (pos_reg == 16'd1) sof_next[15:8] = b;
                    else if (pos_reg == 16'd2) sof_next[7:0] = b;
                    else if (pos_reg == 16'd3) sof_next[31:24] = b;
                    else if (pos_reg == 16'd4) sof_next[23:16] = b;
                    else if (pos_reg == 16'd5) sof_next[39:32] = b;
                    else if (pos_reg == 16'd7 && plen >= 16'd9 && comps >= 8'd1)
                        sf_next[15:8] = b;
                    else if (pos_reg == 16'd10 && plen >= 16'd12 && comps >= 8'd2)
                        sf_next[7:0] = b;
                end else if (marker_reg == jmsp_pkg::M_APP0 ||
                             marker_reg == jmsp_pkg::M_APP1 ||
                             marker_reg == jmsp_pkg::M_APPE) begin
                    if (pos_reg < 16'd4 && b != jmsp_pkg::tag_char(marker_reg, pos_reg[3:0]))
                        tag_ok_next = 1'b0;
                end else if (marker_reg == jmsp_pkg::M_APP2) begin
                    if (pos_reg < 16'd11 && b != jmsp_pkg::tag_char(marker_reg, pos_reg[3:0]))
                        tag_ok_next = 1'b0;
                end
                pos_next = pos_inc;
                if (pos_inc >= plen) commit = 1'b1;
            end
            jmsp_pkg::PH_SCAN: begin
                if (b == jmsp_pkg::M_FF) phase_next = jmsp_pkg::PH_SCAN_FF;
            end
            default: begin
                phase_next = jmsp_pkg::PH_DONE;
            end
        endcase

        if (commit) begin
            phase_next = (marker_reg == jmsp_pkg::M_SOS) ? jmsp_pkg::PH_SCAN
                                                         : jmsp_pkg::PH_IDLE;
        end
    end

    // Commit of a finished segment into the gathered facts
    logic [15:0] plen_c;
    assign plen_c = seglen_next - 16'd2;

    always_comb begin
        info_upd = info_reg;
        if (commit) begin
            if (marker_reg == jmsp_pkg::M_SOS) begin
                info_upd.scans = jmsp_pkg::sat_add(info_reg.scans, 3'd1);
            end else if (marker_reg == jmsp_pkg::M_DQT) begin
                info_upd.dqt_tables = jmsp_pkg::sat_add(info_reg.dqt_tables, dqt_cnt_next);
            end else if (jmsp_pkg::is_frame_marker(marker_reg)) begin
                if (plen_c >= 16'd6) begin
                    info_upd.valid_jpeg  = 1'b1;
                    info_upd.progressive = (marker_reg[1:0] == 2'b10);
                    info_upd.height      = sof_next[15:0];
                    info_upd.width       = sof_next[31:16];
                    info_upd.components  = sof_next[39:32];
                    info_upd.subsampling = jmsp_pkg::subsampling_code(sf_next,
                                                                      sof_next[39:32]);
                end
            end else if (tag_ok_next) begin
                if (marker_reg == jmsp_pkg::M_APP0 && plen_c > 16'd4)
                    info_upd.jfif_seen = 1'b1;
                else if (marker_reg == jmsp_pkg::M_APP1 && plen_c > 16'd4)
                    info_upd.exif_seen = 1'b1;
                else if (marker_reg == jmsp_pkg::M_APP2 && plen_c >= 16'd12)
                    info_upd.icc_seen = 1'b1;
                else if (marker_reg == jmsp_pkg::M_APPE && plen_c > 16'd4)
                    info_upd.adobe_seen = 1'b1;
            end
        end
    end

    assign info_next = info_upd;

    // State registers; the last byte of a file returns everything to reset
    always_ff @(posedge aclk) begin
        if (!aresetn || (step_en && item.last_byte)) begin
            phase_reg   <= jmsp_pkg::PH_SOI_FF;
            marker_reg  <= 8'd0;
            seglen_reg  <= 16'd0;
            pos_reg     <= 16'd0;
            steps_reg   <= 17'd0;
            dqt_idx_reg <= 3'd0;
            dqt_pos_reg <= 8'd0;
            dqt_cnt_reg <= 3'd0;
            sof_reg     <= 40'd0;
            sf_reg      <= 16'h1111;
            tag_ok_reg  <= 1'b1;
            info_reg    <= '0;
        end else if (step_en) begin
            phase_reg   <= phase_next;
            marker_reg  <= marker_next;
            seglen_reg  <= seglen_next;
            pos_reg     <= pos_next;
            steps_reg   <= steps_next;
            dqt_idx_reg <= dqt_idx_next;
            dqt_pos_reg <= dqt_pos_next;
            dqt_cnt_reg <= dqt_cnt_next;
            sof_reg     <= sof_next;
            sf_reg      <= sf_next;
            tag_ok_reg  <= tag_ok_next;
            info_reg    <= info_upd;
        end
    end

endmodule

// ----- rtl/core/jpeg_marker_segment_parser_unit.sv -----
// Top level of the JPEG marker segment parser: input register, parser, result register.
//
// Usage: the s_ channel takes a JPEG file one byte per request (data_byte, with
// last_byte set on the final byte). Every byte is parsed; only the byte flagged
// last_byte produces a request on the m_ channel carrying the header facts.
// Throughput is one byte per cycle while s_ready is high: the parser state updates
// once per byte through compare/select logic between the input register
// and the state registers.
// m_valid rises once the last byte, held in the input register, has been
// parsed into the result register; that parse waits while an earlier result
// is still stalled.
// After the last byte the parser returns to its start-of-file state, so the
// next file may follow immediately.
// Reset (aresetn low, synchronous) empties both registers and clears the parser.
// When the receiver stalls, the result register holds; the input register keeps
// taking bytes as long as the result register is free or the held byte is not
// a last byte; s_ready drops only when a result is stuck behind another one.
module jpeg_marker_segment_parser_unit (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  jmsp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output jmsp_pkg::out_item_t m_data
);

    jmsp_pkg::in_item_t  in_reg;
    logic                in_vld_reg;
    jmsp_pkg::out_item_t out_reg;
    logic                out_vld_reg;
    jmsp_pkg::out_item_t info_next;
    logic                proc;
    logic                out_free;

    // Held byte is parsed unless it is a last byte with the result slot full
    assign out_free = !out_vld_reg || m_ready;
    assign proc     = in_vld_reg && (!in_reg.last_byte || out_free);
    assign s_ready  = !in_vld_reg || proc;

    jmsp_parse_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (proc),
        .item      (in_reg),
        .info_next (info_next)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_reg <= s_data;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (proc && in_reg.last_byte) begin
            out_vld_reg <= 1'b1;
        end else if (m_ready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && in_reg.last_byte) begin
            out_reg <= info_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

`ifndef SYNTH
    // A last byte is never parsed while a result is stalled
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_ready) |-> !(proc && in_reg.last_byte))
        else $error("result overwritten while stalled");

    // A stalled result keeps its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !m_ready) |=> (out_vld_reg && $stable(out_reg)))
        else $error("stalled result changed");

    // No subsampling code without a valid frame
    a_ss_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_vld_reg && !out_reg.valid_jpeg) |-> (out_reg.subsampling == jmsp_pkg::SS_UNKNOWN))
        else $error("subsampling without frame header");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
// Testbench for the JPEG marker segment parser: directed files and random files.
module tb_top;
    import jmsp_pkg::*;

    localparam logic [7:0] M_SOF0  = 8'hC0;
    localparam logic [7:0] M_SOF2  = 8'hC2;
    localparam logic [7:0] M_SOF6  = 8'hC6;
    localparam logic [7:0] M_SOF10 = 8'hCA;
    localparam logic [7:0] M_SOF14 = 8'hCE;
    localparam logic [7:0] M_DHT   = 8'hC4;
    localparam logic [7:0] M_JPG   = 8'hC8;
    localparam logic [7:0] M_DAC   = 8'hCC;
    localparam logic [7:0] M_RST0  = 8'hD0;
    localparam logic [7:0] M_DRI   = 8'hDD;
    localparam logic [7:0] M_COM   = 8'hFE;
    localparam int QUIET_LIMIT = 5000;
    localparam int LONG_HOLD   = 400;
    localparam int N_ROWS      = 10;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready;
    out_item_t m_data;

    jpeg_marker_segment_parser_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    // Shared run control
    int        errors = 0;
    bit        idle_on = 1;
    bit        long_hold = 0;
    out_item_t expected_facts[$];
    logic [7:0] file_bytes[$];

    // Parser state mirror
    logic [3:0]  ph;
    logic [7:0]  mk;
    logic [15:0] seg_len;
    logic [15:0] pos;
    logic [16:0] steps;
    logic [2:0]  tbl_idx;
    logic [7:0]  tbl_left;
    logic [2:0]  tbl_done;
    logic [63:0] sof_acc;
    logic [15:0] samp;
    logic        tag_ok;
    out_item_t   facts;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic void clear_parser();
        ph = PH_SOI_FF; mk = '0; seg_len = '0; pos = '0; steps = '0;
        tbl_idx = '0; tbl_left = '0; tbl_done = '0; sof_acc = '0;
        samp = 16'h1111; tag_ok = 1'b1; facts = '0;
    endfunction

    function automatic bit take_step();
        if (steps >= MAX_STEPS) begin
            ph = PH_DONE;
            return 1'b0;
        end
        steps++;
        return 1'b1;
    endfunction

    function automatic bit frame_marker(logic [7:0] m);
        return m[7:4] == 4'hC && m != M_DHT && m != M_JPG && m != M_DAC;
    endfunction

    function automatic bit restart_code(logic [7:0] b);
        return b >= M_RST0 && b <= M_RST0 + 8'd7;
    endfunction

    function automatic logic [2:0] chroma_code(logic [15:0] sf, logic [7:0] comps);
        int h0, v0, h1, v1;
        h0 = int'(sf[15:12]); v0 = int'(sf[11:8]); h1 = int'(sf[7:4]); v1 = int'(sf[3:0]);
        if (h0 == 0) h0 = 1;
        if (v0 == 0) v0 = 1;
        if (h1 == 0) h1 = 1;
        if (v1 == 0) v1 = 1;
        if (comps == 8'd1) return SS_GRAY;
        if (h0 == h1 && v0 == v1) return SS_444;
        if (h0 == 2 * h1 && v0 == v1) return SS_422;
        if (h0 == 2 * h1 && v0 == 2 * v1) return SS_420;
        if (h0 == h1 && v0 == 2 * v1) return SS_440;
        if (h0 == 4 * h1 && v0 == v1) return SS_411;
        return SS_UNKNOWN;
    endfunction

    function automatic logic [15:0] sat16(logic [15:0] v, int add);
        int s;
        s = int'(v) + add;
        return (s > 65535) ? 16'hFFFF : s[15:0];
    endfunction

    function automatic string app_tag(logic [7:0] m);
        case (m)
            M_APP0: return "JFIF";
            M_APP1: return "Exif";
            M_APP2: return {"ICC_", "PROF", "ILE"};
            M_APPE: return "Adob";
            default: return "";
        endcase
    endfunction

    // Byte that follows an FF outside a segment
    function automatic void take_marker(logic [7:0] b);
        if (b == M_FF) begin
            if (take_step()) ph = PH_SAW_FF;
        end else if (b == M_SOI || b == M_TEM || restart_code(b)) begin
            ph = PH_IDLE;
        end else if (b == M_EOI) begin
            ph = PH_DONE;
        end else begin
            mk = b;
            ph = PH_LEN_HI;
        end
    endfunction

    function automatic void segment_byte(logic [15:0] p, logic [7:0] b);
        logic [15:0] plen;
        logic [7:0]  comps;
        string       tag;
        plen = seg_len - 16'd2;
        comps = sof_acc[39:32];
        if (mk == M_DQT) begin
            if (tbl_idx >= 3'd4) return;
            if (tbl_left == 8'd0) begin
                if (b[3:0] >= 4'd4) begin
                    tbl_idx = 3'd4;
                    return;
                end
                tbl_left = (b[7:4] != 4'd0) ? 8'd128 : 8'd64;
                tbl_idx++;
            end else begin
                tbl_left--;
                if (tbl_left == 8'd0) tbl_done++;
            end
        end else if (frame_marker(mk)) begin
            case (p)
                16'd1: sof_acc[15:8] = b;
                16'd2: sof_acc[7:0] = b;
                16'd3: sof_acc[31:24] = b;
                16'd4: sof_acc[23:16] = b;
                16'd5: sof_acc[39:32] = b;
                16'd7: if (plen >= 9 && comps >= 1) samp[15:8] = b;
                16'd10: if (plen >= 12 && comps >= 2) samp[7:0] = b;
                default: ;
            endcase
        end else begin
            tag = app_tag(mk);
            if (p < tag.len() && b != tag[p]) tag_ok = 1'b0;
        end
    endfunction

    function automatic void close_segment();
        logic [15:0] plen;
        plen = seg_len - 16'd2;
        ph = PH_IDLE;
        if (mk == M_SOS) begin
            facts.scans = sat16(facts.scans, 1);
            ph = PH_SCAN;
        end else if (mk == M_DQT) begin
            facts.dqt_tables = sat16(facts.dqt_tables, int'(tbl_done));
        end else if (frame_marker(mk)) begin
            if (plen >= 6) begin
                facts.valid_jpeg = 1'b1;
                facts.progressive = (mk == M_SOF2 || mk == M_SOF6 ||
                                     mk == M_SOF10 || mk == M_SOF14);
                facts.height = sof_acc[15:0];
                facts.width = sof_acc[31:16];
                facts.components = sof_acc[39:32];
                facts.subsampling = chroma_code(samp, sof_acc[39:32]);
            end
        end else if (tag_ok) begin
            if (mk == M_APP0 && plen > 4) facts.jfif_seen = 1'b1;
            else if (mk == M_APP1 && plen > 4) facts.exif_seen = 1'b1;
            else if (mk == M_APP2 && plen >= 12) facts.icc_seen = 1'b1;
            else if (mk == M_APPE && plen > 4) facts.adobe_seen = 1'b1;
        end
    endfunction

    // Predict the effect of one accepted byte
    function automatic void parse_byte(in_item_t it);
        logic [7:0] b;
        b = it.data_byte;
        case (ph)
            PH_SOI_FF: ph = (b == M_FF) ? PH_SOI_D8 : PH_DONE;
            PH_SOI_D8: ph = (b == M_SOI) ? PH_IDLE : PH_DONE;
            PH_IDLE: if (take_step() && b == M_FF) ph = PH_SAW_FF;
            PH_SAW_FF: take_marker(b);
            PH_LEN_HI: begin
                seg_len = {b, 8'h00};
                ph = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                seg_len[7:0] = b;
                if (seg_len < 16'd2) begin
                    ph = PH_DONE;
                end else begin
                    pos = '0; tbl_idx = '0; tbl_left = '0; tbl_done = '0;
                    sof_acc = '0; samp = 16'h1111; tag_ok = 1'b1;
                    if (seg_len == 16'd2) close_segment();
                    else ph = PH_PAYLOAD;
                end
            end
            PH_PAYLOAD: begin
                segment_byte(pos, b);
                pos++;
                if (pos >= seg_len - 16'd2) close_segment();
            end
            PH_SCAN: if (b == M_FF) ph = PH_SCAN_FF;
            PH_SCAN_FF: begin
                if (b == 8'h00 || restart_code(b)) ph = PH_SCAN;
                else if (take_step()) take_marker(b);
            end
            default: ph = PH_DONE;
        endcase
        if (it.last_byte) begin
            expected_facts.push_back(facts);
            clear_parser();
        end
    endfunction

    // Send one byte, holding valid until it is accepted
    task automatic send_byte(in_item_t it);
        if (idle_on && $urandom_range(0, 7) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge aclk);
        end
        s_valid = 1'b1;
        s_data = it;
        do @(posedge aclk); while (!s_ready);
        parse_byte(it);
        @(negedge aclk);
    endtask

    task automatic send_file();
        in_item_t it;
        for (int i = 0; i < file_bytes.size(); i++) begin
            it.data_byte = file_bytes[i];
            it.last_byte = (i == file_bytes.size() - 1);
            send_byte(it);
        end
        s_valid = 1'b0;
    endtask

    function automatic void push_hex(string s);
        for (int i = 0; i + 1 < s.len(); i += 2)
            file_bytes.push_back(8'(s.substr(i, i + 1).atohex()));
    endfunction

    function automatic void push_segment(logic [7:0] m, int plen);
        logic [15:0] l;
        l = 16'(plen + 2);
        file_bytes.push_back(M_FF);
        file_bytes.push_back(m);
        file_bytes.push_back(l[15:8]);
        file_bytes.push_back(l[7:0]);
    endfunction

    function automatic logic [7:0] rand_factors();
        logic [3:0] h, v;
        h = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'(1 << $urandom_range(0, 2));
        v = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : 4'(1 << $urandom_range(0, 1));
        return {h, v};
    endfunction

    // Random file: mostly well-formed segments with random content, some noise
    function automatic void build_random_file();
        logic [7:0] body[$];
        logic [7:0] m;
        string      tag;
        int         n, plen, comps;
        file_bytes.delete();
        m = 8'h00;
        if ($urandom_range(0, 15) == 0) begin
            repeat ($urandom_range(1, 20)) file_bytes.push_back(8'($urandom));
            return;
        end
        if ($urandom_range(0, 15) == 0) begin
            file_bytes.push_back(($urandom_range(0, 1) == 0) ? M_FF : 8'($urandom));
            file_bytes.push_back(8'($urandom));
        end else begin
            file_bytes.push_back(M_FF);
            file_bytes.push_back(M_SOI);
        end
        repeat ($urandom_range(0, 6)) begin
            body.delete();
            case ($urandom_range(0, 9))
                0: repeat ($urandom_range(1, 3)) file_bytes.push_back(8'($urandom));
                1: begin
                    file_bytes.push_back(M_FF);
                    file_bytes.push_back(M_FF);
                    case ($urandom_range(0, 2))
                        0: file_bytes.push_back(M_TEM);
                        1: file_bytes.push_back(M_RST0 + 8'($urandom_range(0, 7)));
                        default: file_bytes.push_back(M_SOI);
                    endcase
                end
                2: begin
                    case ($urandom_range(0, 4))
                        0: m = M_APP0;
                        1: m = M_APP1;
                        2: m = M_APP2;
                        3: m = M_APPE;
                        default: m = M_APP0 + 8'($urandom_range(3, 15));
                    endcase
                    tag = app_tag(m);
                    if (tag.len() == 0) tag = "JFIF";
                    plen = ($urandom_range(0, 3) == 0) ? $urandom_range(0, tag.len())
                                                       : tag.len() + $urandom_range(0, 4);
                    for (int i = 0; i < plen; i++)
                        body.push_back(i < tag.len() ? 8'(tag[i]) : 8'($urandom));
                    if (plen > 0 && $urandom_range(0, 5) == 0)
                        body[$urandom_range(0, plen - 1)] = 8'($urandom);
                end
                3: begin
                    m = M_DQT;
                    n = ($urandom_range(0, 3) == 0) ? $urandom_range(2, 5) : 1;
                    repeat (n) begin
                        body.push_back({3'b000, 1'($urandom_range(0, 5) == 0),
                                        ($urandom_range(0, 7) == 0) ? 4'($urandom_range(4, 15))
                                                                    : 4'($urandom_range(0, 3))});
                        repeat (body[$][4] ? 128 : 64) body.push_back(8'($urandom));
                    end
                    if ($urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, 70)) if (body.size() > 0) void'(body.pop_back());
                end
                4: begin
                    m = M_SOF0 + 8'($urandom_range(0, 15));
                    comps = $urandom_range(0, 4);
                    body.push_back(8'd8);
                    repeat (4) body.push_back(($urandom_range(0, 3) == 0) ? 8'hFF : 8'($urandom));
                    body.push_back(8'(comps));
                    for (int c = 0; c < comps; c++) begin
                        body.push_back(8'(c + 1));
                        body.push_back(rand_factors());
                        body.push_back(8'($urandom_range(0, 3)));
                    end
                    if ($urandom_range(0, 3) == 0) begin
                        plen = $urandom_range(0, 14);
                        while (body.size() > plen) void'(body.pop_back());
                        while (body.size() < plen) body.push_back(8'($urandom));
                    end
                end
                5: begin
                    m = M_SOS;
                    repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
                end
                6: begin
                    case ($urandom_range(0, 3))
                        0: m = M_DHT;
                        1: m = M_DRI;
                        2: m = M_COM;
                        default: m = 8'h00;
                    endcase
                    repeat ($urandom_range(0, 8)) body.push_back(8'($urandom));
                end
                7: begin
                    if ($urandom_range(0, 3) == 0) begin
                        file_bytes.push_back(M_FF);
                        file_bytes.push_back(8'($urandom));
                        file_bytes.push_back(8'h00);
                        file_bytes.push_back(8'($urandom_range(0, 1)));
                    end
                end
                8: begin
                    file_bytes.push_back(M_FF);
                    file_bytes.push_back(M_EOI);
                    repeat ($urandom_range(0, 4)) file_bytes.push_back(8'($urandom));
                end
                default: begin
                    m = 8'($urandom);
                    repeat ($urandom_range(0, 6)) body.push_back(8'($urandom));
                end
            endcase
            if (body.size() > 0 || m == M_SOS) begin
                push_segment(m, body.size());
                foreach (body[i]) file_bytes.push_back(body[i]);
                // entropy-coded data after a scan header
                if (m == M_SOS) begin
                    repeat ($urandom_range(0, 20)) begin
                        case ($urandom_range(0, 7))
                            0: begin file_bytes.push_back(M_FF); file_bytes.push_back(8'h00); end
                            1: begin
                                file_bytes.push_back(M_FF);
                                file_bytes.push_back(M_RST0 + 8'($urandom_range(0, 7)));
                            end
                            2: file_bytes.push_back(M_FF);
                            default: file_bytes.push_back(8'($urandom_range(0, 254)));
                        endcase
                    end
                end
                m = 8'h00;
            end
        end
        if ($urandom_range(0, 3) != 0) begin
            file_bytes.push_back(M_FF);
            file_bytes.push_back(M_EOI);
        end else if ($urandom_range(0, 1) == 0 && file_bytes.size() > 3) begin
            repeat ($urandom_range(1, 3)) void'(file_bytes.pop_back());
        end
    endfunction

    // Receiver: random stalls, plus one long hold on request
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                long_hold = 0;
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic check_field(string name, int exp_v, int act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // Result checker
    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (expected_facts.size() == 0) begin
                $error("result with no request pending");
                errors++;
            end else begin
                e = expected_facts.pop_front();
                check_field("valid_jpeg", int'(e.valid_jpeg), int'(m_data.valid_jpeg));
                check_field("progressive", int'(e.progressive), int'(m_data.progressive));
                check_field("height", int'(e.height), int'(m_data.height));
                check_field("width", int'(e.width), int'(m_data.width));
                check_field("components", int'(e.components), int'(m_data.components));
                check_field("subsampling", int'(e.subsampling), int'(m_data.subsampling));
                check_field("scans", int'(e.scans), int'(m_data.scans));
                check_field("dqt_tables", int'(e.dqt_tables), int'(m_data.dqt_tables));
                check_field("jfif_seen", int'(e.jfif_seen), int'(m_data.jfif_seen));
                check_field("exif_seen", int'(e.exif_seen), int'(m_data.exif_seen));
                check_field("icc_seen", int'(e.icc_seen), int'(m_data.icc_seen));
                check_field("adobe_seen", int'(e.adobe_seen), int'(m_data.adobe_seen));
            end
        end
    end

    // Watchdog on cycles with no request moving
    always @(posedge aclk) begin
        static int quiet = 0;
        if ((s_valid && s_ready) || (m_valid && m_ready)) quiet = 0;
        else quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Stimulus
    initial begin
        string     row_hex[N_ROWS];
        bit        row_typed[N_ROWS];
        out_item_t row_exp[N_ROWS];
        int        sent;

        s_valid = 1'b0;
        s_data = '0;
        aresetn = 1'b0;
        clear_parser();
        foreach (row_typed[i]) begin
            row_typed[i] = 0;
            row_exp[i] = '0;
        end

        // bad start
        row_hex[0] = "00D8FFD9";                  row_typed[0] = 1;
        // empty file
        row_hex[1] = "FFD8FFD9";                  row_typed[1] = 1;
        // length below two
        row_hex[2] = "FFD8FFC00001FFC0000B";      row_typed[2] = 1;
        row_hex[3] = "FFD8FFE000074A46494600FFD9"; row_typed[3] = 1;
        row_exp[3].jfif_seen = 1'b1;
        // full 4:2:0 frame header with largest dimensions
        row_hex[4] = "FFD8FFC0001108FFFFFFFF0301220002110103110100FFD9"; row_typed[4] = 1;
        row_exp[4].valid_jpeg = 1'b1;
        row_exp[4].height = 16'hFFFF;
        row_exp[4].width = 16'hFFFF;
        row_exp[4].components = 8'd3;
        row_exp[4].subsampling = SS_420;
        row_hex[5] = "FFD8FFC2000B0800010001010111FFD9";
        row_hex[6] = "FFD8FFE100074578696600FFEE00074164786200FFDB000304FFD9";
        // scan with stuffed bytes, restart marker and fill bytes
        row_hex[7] = "FFD8FFDA000212FF00FFD334FFFFFFD9";
        // frame header cut off by the file end
        row_hex[8] = "FFD8FFC000110800";          row_typed[8] = 1;
        row_hex[9] = "FFD8FFE2000E4943435F50524F46494C4500FFFF01FFD0FFD9AB";

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        for (int r = 0; r < N_ROWS; r++) begin
            file_bytes.delete();
            push_hex(row_hex[r]);
            send_file();
            if (row_typed[r]) begin
                void'(expected_facts.pop_back());
                expected_facts.push_back(row_exp[r]);
            end
        end
        wait (expected_facts.size() == 0);
        @(negedge aclk);

        // receiver stalls long while short files keep coming
        long_hold = 1;
        repeat (6) begin
            file_bytes.delete();
            push_hex("FFD8FFDA0002FFD9");
            send_file();
        end
        wait (expected_facts.size() == 0);
        @(negedge aclk);

        sent = 0;
        while (sent < 1000) begin
            build_random_file();
            if (file_bytes.size() == 0) continue;
            sent += file_bytes.size();
            send_file();
        end

        // final stretch without idling
        wait (expected_facts.size() == 0);
        @(negedge aclk);
        idle_on = 0;
        repeat (5) begin
            build_random_file();
            if (file_bytes.size() > 0) send_file();
        end

        wait (expected_facts.size() == 0);
        repeat (10) @(posedge aclk);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule
